@@ rtl/u8cpd_pkg.sv @@
// Shared types, constants and lead byte classification for the UTF-8 code
// point decoder. No dependencies.
`timescale 1ns / 1ps

package u8cpd_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 31;
   localparam int unsigned CountWidth = 3;
   localparam int unsigned ContBits   = 6;

   // Lead byte prefix masks and match values
   localparam logic [ByteWidth-1:0] Lead1Mask  = 8'h80;
   localparam logic [ByteWidth-1:0] Lead1Match = 8'h00;
   localparam logic [ByteWidth-1:0] Lead2Mask  = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead2Match = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead3Mask  = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead3Match = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead4Mask  = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead4Match = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead5Mask  = 8'hFC;
   localparam logic [ByteWidth-1:0] Lead5Match = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead6Mask  = 8'hFE;
   localparam logic [ByteWidth-1:0] Lead6Match = 8'hFC;

   // Surrogate range
   localparam logic [CpWidth-1:0] SurrogateLow  = 31'h0000_D800;
   localparam logic [CpWidth-1:0] SurrogateHigh = 31'h0000_DFFF;

   typedef struct packed {
      logic                  ok;       // legal lead byte
      logic [CountWidth-1:0] need;     // continuation bytes to follow
      logic [ByteWidth-2:0]  payload;  // value bits carried by the lead
   } lead_info_type;

   // Classify a lead byte by its count of leading ones
   function automatic lead_info_type decode_lead(input logic [ByteWidth-1:0] b);
      lead_info_type info;
      info.ok      = 1'b1;
      info.need    = '0;
      info.payload = '0;
      priority if ((b & Lead1Mask) == Lead1Match) begin
         info.need    = 3'd0;
         info.payload = b[6:0];
      end else if ((b & Lead2Mask) == Lead2Match) begin
         info.need    = 3'd1;
         info.payload = {2'b00, b[4:0]};
      end else if ((b & Lead3Mask) == Lead3Match) begin
         info.need    = 3'd2;
         info.payload = {3'b000, b[3:0]};
      end else if ((b & Lead4Mask) == Lead4Match) begin
         info.need    = 3'd3;
         info.payload = {4'b0000, b[2:0]};
      end else if ((b & Lead5Mask) == Lead5Match) begin
         info.need    = 3'd4;
         info.payload = {5'b00000, b[1:0]};
      end else if ((b & Lead6Mask) == Lead6Match) begin
         info.need    = 3'd5;
         info.payload = {6'b000000, b[0]};
      end else begin
         info.ok = 1'b0;
      end
      return info;
   endfunction

endpackage

@@ rtl/utf8_code_point_decoder_unit.sv @@
// UTF-8 code point decoder top level: input register, per-byte decode step
// and result register. Depends on u8cpd_pkg.
`timescale 1ns / 1ps
// Path: an accepted byte is held in the input register, and its result (if
//    any) is then loaded into the result register that drives the outputs.
// Throughput: one byte per cycle unless rsp_stall holds the result register;
//    the single decode step between the two registers sets this figure.
// Reset (synchronous, active high) empties both registers and clears the
//    partial value, the remaining count and the discard flag.

module utf8_code_point_decoder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [u8cpd_pkg::ByteWidth-1:0] req_data_byte,
   input  logic                            req_string_end,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [u8cpd_pkg::CpWidth-1:0]   rsp_code_point,
   output logic                            rsp_bad_sequence,
   output logic                            rsp_string_end_out
);
   import u8cpd_pkg::*;

   // Input register
   logic                  in_valid_ff;
   logic [ByteWidth-1:0]  in_byte_ff;
   logic                  in_end_ff;

   // Decoder state
   logic [CpWidth-1:0]    partial_ff,   partial_in;
   logic [CountWidth-1:0] remaining_ff, remaining_in;
   logic                  discard_ff,   discard_in;

   // Result register
   logic                  out_valid_ff;
   logic [CpWidth-1:0]    out_cp_ff;
   logic                  out_bad_ff;
   logic                  out_end_ff;

   // Step results
   logic                  emit;
   logic                  emit_bad;
   logic [CpWidth-1:0]    emit_cp;
   logic                  advance;
   logic                  take_in;

   lead_info_type         lead;
   logic [CpWidth-1:0]    gathered;
   logic [CountWidth-1:0] left;
   logic                  complete;
   logic [CpWidth-1:0]    done_cp;
   logic                  fail;

   // Move the held byte on once the result register can take a new item
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign take_in   = req_valid && !req_stall;

   // Decode one byte against the current state
   always_comb begin
      lead         = decode_lead(in_byte_ff);
      gathered     = {partial_ff[CpWidth-ContBits-1:0], in_byte_ff[ContBits-1:0]};
      left         = remaining_ff - 3'd1;
      partial_in   = partial_ff;
      remaining_in = remaining_ff;
      discard_in   = discard_ff;
      complete     = 1'b0;
      done_cp      = '0;
      fail         = 1'b0;
      emit         = 1'b0;
      emit_bad     = 1'b0;
      emit_cp      = '0;

      if (discard_ff) begin
         // drop bytes until the string ends
         if (in_end_ff) begin
            discard_in   = 1'b0;
            partial_in   = '0;
            remaining_in = '0;
         end
      end else if (remaining_ff == '0) begin
         if (!lead.ok) begin
            fail = 1'b1;
         end else if (lead.need != '0) begin
            if (in_end_ff) begin
               fail = 1'b1;
            end else begin
               partial_in   = {{(CpWidth-ByteWidth+1){1'b0}}, lead.payload};
               remaining_in = lead.need;
            end
         end else begin
            complete = 1'b1;
            done_cp  = {{(CpWidth-ByteWidth+1){1'b0}}, lead.payload};
         end
      end else begin
         // fold in a continuation byte
         partial_in   = gathered;
         remaining_in = left;
         if (left != '0) begin
            fail = in_end_ff;
         end else begin
            complete = 1'b1;
            done_cp  = gathered;
         end
      end

      // Reject surrogates, otherwise hand out the finished value
      if (complete) begin
         if (done_cp >= SurrogateLow && done_cp <= SurrogateHigh) begin
            fail = 1'b1;
         end else begin
            emit         = 1'b1;
            emit_cp      = done_cp;
            partial_in   = '0;
            remaining_in = '0;
         end
      end

      if (fail) begin
         emit         = 1'b1;
         emit_bad     = 1'b1;
         emit_cp      = '0;
         partial_in   = '0;
         remaining_in = '0;
         discard_in   = !in_end_ff;
      end
   end

   // Input register: load on accept, empty when the byte moves on
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (take_in) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
      if (take_in) begin
         in_byte_ff <= req_data_byte;
         in_end_ff  <= req_string_end;
      end
   end

   // Decoder state: advance once per byte
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff   <= '0;
         remaining_ff <= '0;
         discard_ff   <= 1'b0;
      end else if (advance) begin
         partial_ff   <= partial_in;
         remaining_ff <= remaining_in;
         discard_ff   <= discard_in;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && emit) begin
         out_cp_ff  <= emit_cp;
         out_bad_ff <= emit_bad;
         out_end_ff <= in_end_ff;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_code_point     = out_cp_ff;
   assign rsp_bad_sequence   = out_bad_ff;
   assign rsp_string_end_out = out_end_ff;

endmodule
